>>> rtl/core/fsm_pkg.sv
// Package with shared widths and types for the fraction sum and maximum block.
package fsm_pkg;
  localparam int W = 32;
  localparam int CW = $clog2(W + 1);

  typedef enum logic [1:0] {
    DIV_IDLE = 2'b01,
    DIV_RUN  = 2'b10
  } div_state_t;

  typedef struct packed {
    logic start;
    logic [W-1:0] dividend;
    logic [W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [W-1:0] quot;
    logic [W-1:0] rem;
  } div_rsp_t;
endpackage

>>> rtl/core/fsm_div.sv
// Bit-serial signed divider with C truncation: one quotient bit per cycle.
module fsm_div (
  input  logic              clk,
  input  logic              rst_n,
  input  fsm_pkg::div_req_t req,
  output fsm_pkg::div_rsp_t rsp
);
  fsm_pkg::div_state_t state_r, state_nxt;
  logic [fsm_pkg::CW-1:0] cnt_r, cnt_nxt;
  logic [fsm_pkg::W-1:0] rem_r, rem_nxt, quo_r, quo_nxt, dvs_r, dvs_nxt;
  logic qneg_r, qneg_nxt, rneg_r, rneg_nxt, done_r, done_nxt;
  logic [fsm_pkg::W:0] trial;
  logic [fsm_pkg::W-1:0] shifted;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    dvs_nxt = dvs_r;
    qneg_nxt = qneg_r;
    rneg_nxt = rneg_r;
    done_nxt = 1'b0;
    shifted = {rem_r[fsm_pkg::W-2:0], quo_r[fsm_pkg::W-1]};
    trial = {1'b0, shifted} - {1'b0, dvs_r};
    unique case (state_r)
      fsm_pkg::DIV_IDLE: begin
        if (req.start) begin
          quo_nxt = req.dividend[fsm_pkg::W-1] ? -req.dividend : req.dividend;
          dvs_nxt = req.divisor[fsm_pkg::W-1] ? -req.divisor : req.divisor;
          rem_nxt = '0;
          qneg_nxt = req.dividend[fsm_pkg::W-1] ^ req.divisor[fsm_pkg::W-1];
          rneg_nxt = req.dividend[fsm_pkg::W-1];
          cnt_nxt = '0;
          state_nxt = fsm_pkg::DIV_RUN;
        end
      end
      fsm_pkg::DIV_RUN: begin
        // Remainder can reach W bits when carry out of shift; use carry bit.
        if (rem_r[fsm_pkg::W-1] || !trial[fsm_pkg::W]) begin
          rem_nxt = shifted - dvs_r;
          quo_nxt = {quo_r[fsm_pkg::W-2:0], 1'b1};
        end else begin
          rem_nxt = shifted;
          quo_nxt = {quo_r[fsm_pkg::W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == fsm_pkg::CW'(fsm_pkg::W - 1)) begin
          state_nxt = fsm_pkg::DIV_IDLE;
          done_nxt = 1'b1;
        end
      end
      default: state_nxt = fsm_pkg::DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fsm_pkg::DIV_IDLE;
      done_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    qneg_r <= qneg_nxt;
    rneg_r <= rneg_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = qneg_r ? -quo_r : quo_r;
  assign rsp.rem = rneg_r ? -rem_r : rem_r;
endmodule

>>> rtl/core/fsm_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle, 64-bit product.
module fsm_mul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [fsm_pkg::W-1:0]      a,
  input  logic [fsm_pkg::W-1:0]      b,
  output logic                       done,
  output logic [2*fsm_pkg::W-1:0]    prod
);
  logic busy_r, done_r;
  logic [fsm_pkg::CW-1:0] cnt_r;
  logic [2*fsm_pkg::W-1:0] acc_r, mcd_r;
  logic [fsm_pkg::W-1:0] mpr_r;

  // The multiplicand is sign-extended; low W multiplier bits give the product mod 2^2W,
  // with a correction for a negative multiplier applied at start.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
        mcd_r <= {{fsm_pkg::W{a[fsm_pkg::W-1]}}, a};
        mpr_r <= b;
        acc_r <= b[fsm_pkg::W-1] ? -({a, {fsm_pkg::W{1'b0}}}) : '0;
      end else if (busy_r) begin
        if (mpr_r[0]) acc_r <= acc_r + mcd_r;
        mcd_r <= mcd_r << 1;
        mpr_r <= mpr_r >> 1;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == fsm_pkg::CW'(fsm_pkg::W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
  assign done = done_r;
  assign prod = acc_r;
endmodule

>>> rtl/core/fraction_sum_and_max.sv
// Top level of the running fraction sum and maximum block.
// Sequence: a first or ignored item's result is valid in the cycle after acceptance; a later item
// runs five serial products, one division per Euclid step and two final divisions, except
// when the sum denominator wraps to 0, which skips the divisions.
// One transaction at a time; the next input is taken only after the result leaves the output register.
// Reset (synchronous, rst_n low): sum 0/1, maximum 0/1, no run open, no result.
module fraction_sum_and_max (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_numerator,
  input  logic [31:0] in_denominator,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_sum_numerator,
  output logic [31:0] out_sum_denominator,
  output logic [31:0] out_max_numerator,
  output logic [31:0] out_max_denominator,
  output logic        out_run_end,
  output logic        out_zero_denominator,
  output logic        out_sum_overflow
);
  localparam int W = fsm_pkg::W;

  // One-hot sequencer. Products: acc_n*d, n*acc_d, acc_d*d, n*best_d, best_n*d.
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MUL  = 9'b000000010,
    S_MWT  = 9'b000000100,
    S_GCD  = 9'b000001000,
    S_GWT  = 9'b000010000,
    S_QN   = 9'b000100000,
    S_QNW  = 9'b001000000,
    S_QD   = 9'b010000000,
    S_QDW  = 9'b100000000
  } state_t;

  state_t state_r;
  logic [W-1:0] n_r, d_r, acc_n_r, acc_d_r, best_n_r, best_d_r;
  logic last_r, open_r;
  logic [W-1:0] sn_r, sd_r, ga_r, gb_r, new_n_r;
  logic [2*W-1:0] lhs_r;
  logic [2:0] mi_r;
  logic ovf_r, gt_r;

  // The result holds in the output register; the block waits while it is full.
  logic full_r;
  assign in_stall = (state_r != S_IDLE) || full_r;
  assign out_valid = full_r;

  logic mul_start, mul_done;
  logic [W-1:0] ma, mb;
  logic [2*W-1:0] prod;
  fsm_mul u_mul (.clk(clk), .rst_n(rst_n), .start(mul_start), .a(ma), .b(mb),
                 .done(mul_done), .prod(prod));

  fsm_pkg::div_req_t dreq;
  fsm_pkg::div_rsp_t drsp;
  fsm_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  always_comb begin
    case (mi_r)
      3'd0: begin ma = acc_n_r; mb = d_r; end
      3'd1: begin ma = n_r; mb = acc_d_r; end
      3'd2: begin ma = acc_d_r; mb = d_r; end
      3'd3: begin ma = n_r; mb = best_d_r; end
      default: begin ma = best_n_r; mb = d_r; end
    endcase
  end
  assign mul_start = (state_r == S_MUL);

  always_comb begin
    dreq.start = 1'b0;
    dreq.dividend = ga_r;
    dreq.divisor = gb_r;
    if (state_r == S_GCD) dreq.start = 1'b1;
    if (state_r == S_QN) begin
      dreq.start = 1'b1; dreq.dividend = sn_r; dreq.divisor = ga_r;
    end
    if (state_r == S_QD) begin
      dreq.start = 1'b1; dreq.dividend = sd_r; dreq.divisor = ga_r;
    end
  end

  // Maximum comparison: reversed when the denominator signs differ.
  logic pos, gt_now;
  assign pos = (!d_r[W-1] && d_r != '0) == (!best_d_r[W-1] && best_d_r != '0);
  assign gt_now = pos ? ($signed(lhs_r) > $signed(prod)) : ($signed(lhs_r) < $signed(prod));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      full_r <= 1'b0;
      open_r <= 1'b0;
      acc_n_r <= '0; acc_d_r <= W'(1);
      best_n_r <= '0; best_d_r <= W'(1);
    end else begin
      if (full_r && !out_stall) full_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            n_r <= in_numerator; d_r <= in_denominator; last_r <= in_last;
            out_sum_overflow <= 1'b0;
            out_zero_denominator <= 1'b0;
            out_run_end <= 1'b0;
            if (in_denominator == '0) begin
              out_zero_denominator <= 1'b1;
              out_sum_numerator <= acc_n_r; out_sum_denominator <= acc_d_r;
              out_max_numerator <= best_n_r; out_max_denominator <= best_d_r;
              full_r <= 1'b1;
            end else if (!open_r) begin
              acc_n_r <= in_numerator; acc_d_r <= in_denominator;
              best_n_r <= in_numerator; best_d_r <= in_denominator;
              out_sum_numerator <= in_numerator; out_sum_denominator <= in_denominator;
              out_max_numerator <= in_numerator; out_max_denominator <= in_denominator;
              out_run_end <= in_last;
              open_r <= !in_last;
              full_r <= 1'b1;
            end else begin
              mi_r <= 3'd0;
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: state_r <= S_MWT;
        S_MWT: begin
          if (mul_done) begin
            case (mi_r)
              3'd0: sn_r <= prod[W-1:0];
              3'd1: sn_r <= sn_r + prod[W-1:0];
              3'd2: sd_r <= prod[W-1:0];
              3'd3: lhs_r <= prod;
              default: gt_r <= gt_now;
            endcase
            if (mi_r == 3'd4) begin
              ovf_r <= (sd_r == '0);
              ga_r <= sn_r; gb_r <= sd_r;
              state_r <= (sd_r == '0) ? S_QDW : S_GCD;
            end else begin
              mi_r <= mi_r + 3'd1;
              state_r <= S_MUL;
            end
          end
        end
        S_GCD: state_r <= S_GWT;
        S_GWT: begin
          if (drsp.done) begin
            ga_r <= gb_r; gb_r <= drsp.rem;
            state_r <= (drsp.rem == '0) ? S_QN : S_GCD;
          end
        end
        S_QN: state_r <= S_QNW;
        S_QNW: if (drsp.done) begin new_n_r <= drsp.quot; state_r <= S_QD; end
        S_QD: state_r <= S_QDW;
        S_QDW: begin
          if (ovf_r || drsp.done) begin
            logic [W-1:0] sum_n, sum_d, mx_n, mx_d;
            sum_n = ovf_r ? acc_n_r : new_n_r;
            sum_d = ovf_r ? acc_d_r : drsp.quot;
            mx_n = gt_r ? n_r : best_n_r;
            mx_d = gt_r ? d_r : best_d_r;
            acc_n_r <= sum_n; acc_d_r <= sum_d;
            best_n_r <= mx_n; best_d_r <= mx_d;
            out_sum_numerator <= sum_n; out_sum_denominator <= sum_d;
            out_max_numerator <= mx_n; out_max_denominator <= mx_d;
            out_sum_overflow <= ovf_r;
            out_run_end <= last_r;
            open_r <= !last_r;
            full_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

>>> rtl/core/fsm_checker.sv
// Port-level checker for the fraction sum and maximum block, with its bind.
module fsm_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_run_end,
  input logic out_zero_denominator,
  input logic out_sum_overflow
);
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_denominator |-> !out_run_end && !out_sum_overflow)
    else $error("zero denominator result carries other flags");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while result pending");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall) else $error("second transaction overlapped");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
endmodule

bind fraction_sum_and_max fsm_checker u_chk (.*);

>>> bench/fraction_sum_and_max_tb.sv
// Self-checking testbench for the running fraction sum and maximum block.
`timescale 1ns / 1ps

module fraction_sum_and_max_tb;

  typedef struct {
    logic [31:0] num;
    logic [31:0] den;
    logic        last;
  } fraction_t;

  typedef struct {
    logic [31:0] sum_num;
    logic [31:0] sum_den;
    logic [31:0] max_num;
    logic [31:0] max_den;
    logic        run_end;
    logic        zero_den;
    logic        sum_ovf;
  } running_t;

  typedef logic bool_t;

  localparam longint CYCLE_LIMIT = 10_000_000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_numerator = '0;
  logic [31:0] in_denominator = '0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_sum_numerator;
  logic [31:0] out_sum_denominator;
  logic [31:0] out_max_numerator;
  logic [31:0] out_max_denominator;
  logic        out_run_end;
  logic        out_zero_denominator;
  logic        out_sum_overflow;

  fraction_t pending_fractions[$];
  running_t  expected_totals[$];
  int        mismatch_count = 0;
  longint    cycle_count = 0;
  bool_t     stimulus_done;

  // Predictor state, mirroring the block's registers.
  logic signed [31:0] acc_num, acc_den, best_num, best_den;
  logic               run_open;

  fraction_sum_and_max DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Euclid GCD with truncated remainders, so the sign follows the operands as in C.
  function automatic logic signed [31:0] trunc_gcd(logic signed [31:0] a,
                                                    logic signed [31:0] b);
    logic signed [31:0] t;
    while (b != 0) begin
      // The most negative value modulo minus one is zero; avoid the overflow trap.
      t = (b == -1) ? 32'sd0 : a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // Quotient with wrap at 32 bits (most negative over minus one wraps to itself).
  function automatic logic signed [31:0] wrap_div(logic signed [31:0] a,
                                                   logic signed [31:0] b);
    if (b == -1) return -a;
    return a / b;
  endfunction

  // Strictly greater fraction test with exact 64-bit cross products.
  function automatic logic frac_greater(logic signed [31:0] n, logic signed [31:0] d,
                                        logic signed [31:0] bn, logic signed [31:0] bd);
    logic signed [63:0] lhs, rhs;
    lhs = 64'(n) * 64'(bd);
    rhs = 64'(bn) * 64'(d);
    if ((d > 0) == (bd > 0)) return lhs > rhs;
    return lhs < rhs;
  endfunction

  // Advances the predictor by one fraction and returns the running totals it reports.
  function automatic running_t accumulate_fraction(fraction_t f);
    running_t r;
    logic signed [31:0] n, d, sn, sd, g;
    n = f.num;
    d = f.den;
    r.zero_den = (d == 0);
    r.sum_ovf = 1'b0;
    r.run_end = 1'b0;
    if (d != 0) begin
      if (!run_open) begin
        acc_num = n;
        acc_den = d;
        best_num = n;
        best_den = d;
      end else begin
        sn = acc_num * d + n * acc_den;
        sd = acc_den * d;
        if (sd == 0) begin
          r.sum_ovf = 1'b1;
        end else begin
          g = trunc_gcd(sn, sd);
          acc_num = wrap_div(sn, g);
          acc_den = wrap_div(sd, g);
        end
        if (frac_greater(n, d, best_num, best_den)) begin
          best_num = n;
          best_den = d;
        end
      end
      run_open = !f.last;
      r.run_end = f.last;
    end
    r.sum_num = acc_num;
    r.sum_den = acc_den;
    r.max_num = best_num;
    r.max_den = best_den;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch in %s: got %h, expected %h", field, got, want);
    mismatch_count++;
  endtask

  // Mostly short gaps, occasionally a long one, sometimes none at all.
  function automatic int gap_length();
    int p;
    p = $urandom_range(99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(3, 1);
    return $urandom_range(300, 20);
  endfunction

  function automatic logic [31:0] random_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(7) - 3;
      3: return $urandom_range(200) - 100;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_fraction(logic [31:0] n, logic [31:0] d, logic l);
    fraction_t f;
    f.num = n;
    f.den = d;
    f.last = l;
    pending_fractions.push_back(f);
  endtask

  initial begin
    int run_len;
    logic [31:0] d;
    stimulus_done = 1'b0;
    acc_num = 0;
    acc_den = 1;
    best_num = 0;
    best_den = 1;
    run_open = 1'b0;
    // Directed transactions: extremes, zero denominators, wrap cases, sign flips.
    queue_fraction(32'd0, 32'd0, 1'b1);             // ignored before any run
    queue_fraction(32'd1, 32'd2, 1'b0);
    queue_fraction(32'd1, 32'd3, 1'b0);
    queue_fraction(32'd5, 32'd0, 1'b1);             // ignored, last not honored
    queue_fraction(-32'sd1, -32'sd6, 1'b1);         // negative denominator
    queue_fraction(32'h8000_0000, 32'h7fff_ffff, 1'b0);
    queue_fraction(32'h7fff_ffff, 32'h8000_0000, 1'b0);
    queue_fraction(32'hffff_ffff, 32'hffff_ffff, 1'b1);
    queue_fraction(32'd3, 32'h0001_0000, 1'b0);     // denominators wrap to zero
    queue_fraction(32'd7, 32'h0001_0000, 1'b0);
    queue_fraction(32'd2, 32'd1, 1'b1);
    queue_fraction(32'h8000_0000, 32'd1, 1'b0);     // most negative over one; the next sum divides by minus one
    queue_fraction(32'd0, 32'hffff_ffff, 1'b0);
    queue_fraction(32'hffff_ffff, 32'hffff_ffff, 1'b1);
    queue_fraction(32'd4, 32'd6, 1'b1);             // single item run
    queue_fraction(32'h8000_0000, 32'h8000_0000, 1'b0);
    queue_fraction(32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
    // Random runs: mostly well-formed with random content, some zero denominators.
    while (pending_fractions.size() < 440) begin
      run_len = ($urandom_range(9) == 0) ? $urandom_range(30, 10) : $urandom_range(5, 1);
      for (int i = 0; i < run_len; i++) begin
        d = random_value();
        if ($urandom_range(19) == 0) d = 32'd0;
        queue_fraction(random_value(), d, i == run_len - 1);
      end
    end
    stimulus_done = 1'b1;
  end

  // Driver: presents queued fractions, with random gaps between transactions.
  int drive_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_totals.push_back(accumulate_fraction('{in_numerator, in_denominator,
                                                       in_last}));
        pending_fractions.pop_front();
        drive_gap <= gap_length();
        in_valid <= 1'b0;
      end else if (!in_valid) begin
        if (drive_gap > 0) begin
          drive_gap <= drive_gap - 1;
        end else if (pending_fractions.size() > 0) begin
          in_valid <= 1'b1;
          in_numerator <= pending_fractions[0].num;
          in_denominator <= pending_fractions[0].den;
          in_last <= pending_fractions[0].last;
        end
      end
    end
  end

  // Monitor: checks each result transaction and stalls the output at random.
  int stall_left = 0;
  always @(posedge clk) begin
    running_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_totals.size() == 0) begin
          report_mismatch("unexpected result", out_sum_numerator, 32'd0);
        end else begin
          want = expected_totals.pop_front();
          if (out_sum_numerator !== want.sum_num)
            report_mismatch("sum_numerator", out_sum_numerator, want.sum_num);
          if (out_sum_denominator !== want.sum_den)
            report_mismatch("sum_denominator", out_sum_denominator, want.sum_den);
          if (out_max_numerator !== want.max_num)
            report_mismatch("max_numerator", out_max_numerator, want.max_num);
          if (out_max_denominator !== want.max_den)
            report_mismatch("max_denominator", out_max_denominator, want.max_den);
          if (out_run_end !== want.run_end)
            report_mismatch("run_end", 32'(out_run_end), 32'(want.run_end));
          if (out_zero_denominator !== want.zero_den)
            report_mismatch("zero_denominator", 32'(out_zero_denominator),
                            32'(want.zero_den));
          if (out_sum_overflow !== want.sum_ovf)
            report_mismatch("sum_overflow", 32'(out_sum_overflow), 32'(want.sum_ovf));
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        stall_left <= gap_length();
        out_stall <= 1'b0;
      end
    end
  end

  // Reset, then wait for the queues to drain; a cycle counter guards against a hang.
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    while (!(stimulus_done && pending_fractions.size() == 0 && !in_valid
             && expected_totals.size() == 0) && cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL fraction_sum_and_max");
    end else begin
      // Keep the clock running so that any stray result would still be caught.
      repeat (400) @(posedge clk);
      if (mismatch_count == 0) begin
        $display("PASS fraction_sum_and_max");
      end else begin
        $display("FAIL fraction_sum_and_max");
      end
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/fsm_pkg.sv
rtl/core/fsm_div.sv
rtl/core/fsm_mul.sv
rtl/core/fraction_sum_and_max.sv
rtl/core/fsm_checker.sv
bench/fraction_sum_and_max_tb.sv
